>>> design/btu16_pkg.sv
// ============================================================================
// btu16_pkg
// Shared types and constants for the mark-aware text to UTF-16 decoder.
// ============================================================================
package btu16_pkg;

    // Text mode codes
    localparam logic [1:0] MODE_DETECT = 2'd0;
    localparam logic [1:0] MODE_UTF8   = 2'd1;
    localparam logic [1:0] MODE_LE     = 2'd2;
    localparam logic [1:0] MODE_BE     = 2'd3;

    // Byte order mark bytes
    localparam logic [7:0] BOM_EF = 8'hEF;
    localparam logic [7:0] BOM_BB = 8'hBB;
    localparam logic [7:0] BOM_BF = 8'hBF;
    localparam logic [7:0] BOM_FF = 8'hFF;
    localparam logic [7:0] BOM_FE = 8'hFE;

    // Carriage return code unit, removed from the output
    localparam logic [15:0] CR_UNIT = 16'h000D;

    // Decoder state carried from byte to byte
    typedef struct packed {
        logic [1:0]  text_mode;
        logic [1:0]  byte_position;
        logic [7:0]  held_first_byte;
        logic        mark_prefix_match;
        logic [15:0] unit_accumulator;
        logic [1:0]  bytes_still_needed;
        logic        unit_pending;
        logic [7:0]  pair_low_byte;
        logic        pair_half_held;
    } t_dec_state;

    // Result of one byte
    typedef struct packed {
        logic        emit;
        logic [15:0] code_unit;
        logic        unit_valid;
        logic        text_end;
    } t_dec_result;

endpackage

>>> design/btu16_decode.sv
// ============================================================================
// btu16_decode
// Next-state and result logic for one text byte: mark detection, lenient
// UTF-8 gathering, UTF-16 pairing and carriage return removal.
// ============================================================================
module btu16_decode (
    input  btu16_pkg::t_dec_state  i_state,
    input  logic [7:0]             i_text_byte,
    input  logic                   i_final_byte,
    output btu16_pkg::t_dec_state  o_state,
    output btu16_pkg::t_dec_result o_result
);

    // UTF-8 step on the current byte, from the current gathering state
    logic        u8_have;
    logic [15:0] u8_unit;
    logic [15:0] u8_acc;
    logic [1:0]  u8_need;
    logic        u8_pending;

    always_comb begin
        logic [15:0] bits;
        logic [1:0]  need_dec;
        bits       = {10'd0, i_text_byte[5:0]};
        need_dec   = 2'd0;
        u8_have    = 1'b0;
        u8_unit    = 16'd0;
        u8_acc     = i_state.unit_accumulator;
        u8_need    = i_state.bytes_still_needed;
        u8_pending = i_state.unit_pending;
        if (i_state.unit_pending) begin
            if (i_state.bytes_still_needed >= 2'd2) begin
                bits = {4'd0, i_text_byte[5:0], 6'd0};
            end
            need_dec = (i_state.bytes_still_needed != 2'd0) ?
                       i_state.bytes_still_needed - 2'd1 : 2'd0;
            u8_need  = need_dec;
            if (need_dec == 2'd0) begin
                u8_pending = 1'b0;
                u8_unit    = i_state.unit_accumulator | bits;
                u8_acc     = 16'd0;
                u8_have    = 1'b1;
            end else begin
                u8_acc = i_state.unit_accumulator | bits;
            end
        end else if (!i_text_byte[7]) begin
            u8_unit = {8'd0, i_text_byte};
            u8_have = 1'b1;
        end else if (i_text_byte[7:5] == 3'b111) begin
            // three-byte or longer lead keeps its low 4 bits
            u8_acc     = {i_text_byte[3:0], 12'd0};
            u8_need    = 2'd2;
            u8_pending = 1'b1;
        end else begin
            // two-byte lead, or a stray continuation byte, keeps its low 6 bits
            u8_acc     = {4'd0, i_text_byte[5:0], 6'd0};
            u8_need    = 2'd1;
            u8_pending = 1'b1;
        end
    end

    // Mode handling, final byte and carriage return filter
    always_comb begin
        btu16_pkg::t_dec_state n_st;
        logic        have;
        logic        use_u8;
        logic        drop;
        logic [15:0] unit;
        n_st   = i_state;
        have   = 1'b0;
        use_u8 = 1'b0;
        drop   = 1'b0;
        unit   = 16'd0;

        unique case (i_state.text_mode)
            btu16_pkg::MODE_DETECT: begin
                if (i_state.byte_position == 2'd0) begin
                    use_u8 = 1'b1;
                    if (i_text_byte == btu16_pkg::BOM_EF ||
                        i_text_byte == btu16_pkg::BOM_FF ||
                        i_text_byte == btu16_pkg::BOM_FE) begin
                        n_st.held_first_byte = i_text_byte;
                        n_st.byte_position   = 2'd1;
                    end else begin
                        n_st.text_mode = btu16_pkg::MODE_UTF8;
                    end
                end else if (i_state.byte_position == 2'd1) begin
                    if (i_state.held_first_byte == btu16_pkg::BOM_FF &&
                        i_text_byte == btu16_pkg::BOM_FE) begin
                        n_st.text_mode = btu16_pkg::MODE_LE;
                        drop           = 1'b1;
                    end else if (i_state.held_first_byte == btu16_pkg::BOM_FE &&
                                 i_text_byte == btu16_pkg::BOM_FF) begin
                        n_st.text_mode = btu16_pkg::MODE_BE;
                        drop           = 1'b1;
                    end else if (i_state.held_first_byte == btu16_pkg::BOM_EF &&
                                 i_text_byte == btu16_pkg::BOM_BB) begin
                        n_st.mark_prefix_match = 1'b1;
                        n_st.byte_position     = 2'd2;
                        use_u8                 = 1'b1;
                    end else begin
                        n_st.text_mode = btu16_pkg::MODE_UTF8;
                        use_u8         = 1'b1;
                    end
                end else begin
                    n_st.text_mode = btu16_pkg::MODE_UTF8;
                    if (i_state.mark_prefix_match && i_text_byte == btu16_pkg::BOM_BF) begin
                        drop = 1'b1;
                    end else begin
                        use_u8 = 1'b1;
                    end
                end
            end
            btu16_pkg::MODE_UTF8: begin
                use_u8 = 1'b1;
            end
            btu16_pkg::MODE_LE, btu16_pkg::MODE_BE: begin
                if (i_state.pair_half_held) begin
                    unit = (i_state.text_mode == btu16_pkg::MODE_LE) ?
                           {i_text_byte, i_state.pair_low_byte} :
                           {i_state.pair_low_byte, i_text_byte};
                    n_st.pair_half_held = 1'b0;
                    n_st.pair_low_byte  = 8'd0;
                    have                = 1'b1;
                end else begin
                    n_st.pair_low_byte  = i_text_byte;
                    n_st.pair_half_held = 1'b1;
                end
            end
        endcase

        // UTF-8 gathering state and mark drop
        if (use_u8) begin
            n_st.unit_accumulator   = u8_acc;
            n_st.bytes_still_needed = u8_need;
            n_st.unit_pending       = u8_pending;
            have                    = u8_have;
            unit                    = u8_unit;
        end else if (drop) begin
            n_st.unit_accumulator   = 16'd0;
            n_st.bytes_still_needed = 2'd0;
            n_st.unit_pending       = 1'b0;
        end

        // last byte flushes a partly gathered unit
        if (i_final_byte && !have && n_st.unit_pending) begin
            unit = n_st.unit_accumulator;
            have = 1'b1;
        end
        if (have && unit == btu16_pkg::CR_UNIT) begin
            have = 1'b0;
        end

        // new text starts after the last byte
        if (i_final_byte) begin
            n_st = '0;
        end

        o_state             = n_st;
        o_result.emit       = i_final_byte | have;
        o_result.code_unit  = have ? unit : 16'd0;
        o_result.unit_valid = have;
        o_result.text_end   = i_final_byte;
    end

endmodule

>>> design/bom_text_to_utf16_decoder.sv
// ============================================================================
// bom_text_to_utf16_decoder
// Byte order mark aware text decoder producing 16-bit code units.
// ============================================================================
// One byte enters per cycle while the result side keeps up, and at most one
// code unit leaves per byte; each byte passes the input register, then the
// result register. The decode state update is one shallow pass of logic
// between those registers, so throughput is one byte per clock whenever the
// result side takes its transactions. The input register lets one more byte
// be taken while a result waits. Bytes that yield no unit (mark bytes, UTF-8
// lead bytes, the first half of a UTF-16 pair, carriage returns) produce no
// output transaction, except the last byte of a text, which always produces
// one with o_text_end set. Mark detection restarts after every last byte.
// ============================================================================
module bom_text_to_utf16_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_final_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_code_unit,
    output logic        o_unit_valid,
    output logic        o_text_end
);

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_final;
    logic                   r_out_valid;
    btu16_pkg::t_dec_result r_out;
    btu16_pkg::t_dec_state  r_state;
    btu16_pkg::t_dec_state  n_state;
    btu16_pkg::t_dec_result n_result;
    logic                   adv;

    // byte moves from the input register into the result register
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte  <= i_text_byte;
            r_in_final <= i_final_byte;
        end
    end

    btu16_decode u_decode (
        .i_state      (r_state),
        .i_text_byte  (r_in_byte),
        .i_final_byte (r_in_final),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    // decode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (adv) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= n_result.emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_code_unit  = r_out.code_unit;
    assign o_unit_valid = r_out.unit_valid;
    assign o_text_end   = r_out.text_end;

    // a result without the end mark always carries a unit
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.text_end) |-> r_out.unit_valid)
        else $error("result without unit and without end mark");

    // carriage returns never leave the block
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.unit_valid) |-> (r_out.code_unit != btu16_pkg::CR_UNIT))
        else $error("carriage return emitted");

    // an empty result carries a zero code unit
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.unit_valid) |-> (r_out.code_unit == 16'd0))
        else $error("nonzero code unit on empty result");

    // the last byte returns the decoder to mark detection
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_final) |=>
        (r_state.text_mode == btu16_pkg::MODE_DETECT && !r_state.unit_pending &&
         !r_state.pair_half_held && r_state.byte_position == 2'd0))
        else $error("state not cleared after last byte");

endmodule
